FILE: rtl/multibyte_delimiter_field_splitter_defines.svh
// Assertion macros used by the field splitter core (mdfs_core).
`ifndef MULTIBYTE_DELIMITER_FIELD_SPLITTER_DEFINES_SVH
`define MULTIBYTE_DELIMITER_FIELD_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MDFS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mdfs assertion failed");

// Next-cycle implication, disabled during reset.
`define MDFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mdfs assertion failed");

`endif

FILE: rtl/mdfs_pkg.sv
// Types and constants for the multibyte delimiter field splitter.
package mdfs_pkg;

    localparam int MAX_SEP_BYTES = 8;
    localparam int SEP_LEN_BITS  = 4;
    localparam int POS_BITS      = 16;
    localparam int FIELD_BITS    = 10;
    localparam int MAX_FIELDS    = 1024;
    localparam int OUT_POS_BITS  = 16;

    localparam int ADDR_BITS     = 5;
    localparam int DATA_BITS     = 64;

    localparam int FIFO_DEPTH    = 4;
    localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS      = PTR_BITS + 1;

    typedef logic [POS_BITS-1:0]   pos_t;
    typedef logic [FIELD_BITS-1:0] field_t;
    typedef logic [SEP_LEN_BITS-1:0] sep_len_t;

    localparam pos_t     POS_MAX   = {POS_BITS{1'b1}};
    localparam field_t   FIELD_MAX = FIELD_BITS'(MAX_FIELDS - 1);
    localparam logic [7:0] SPACE   = 8'h20;

    // Register indexes (paddr[4:3])
    localparam logic [1:0] REG_SEP_BYTES = 2'd0;
    localparam logic [1:0] REG_SEP_LEN   = 2'd1;
    localparam logic [1:0] REG_TRIM      = 2'd2;

    typedef struct packed {
        logic [8*MAX_SEP_BYTES-1:0] sep_bytes;
        sep_len_t                   sep_len;   // effective length, 1..MAX_SEP_BYTES
        logic                       trim;
    } cfg_t;

    typedef struct packed {
        field_t                  field_number;
        logic [OUT_POS_BITS-1:0] field_offset;
        logic [OUT_POS_BITS-1:0] field_length;
        logic                    last_field;
        logic                    line_overflow;
    } res_t;

endpackage

FILE: rtl/mdfs_regs.sv
// APB configuration registers of the field splitter.
module mdfs_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mdfs_pkg::ADDR_BITS-1:0] paddr,
    input  logic [mdfs_pkg::DATA_BITS-1:0] pwdata,
    output logic [mdfs_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output mdfs_pkg::cfg_t                 cfg
);

    logic [8*mdfs_pkg::MAX_SEP_BYTES-1:0] sep_bytes_reg;
    mdfs_pkg::sep_len_t                   sep_len_reg;
    logic                                 trim_reg;
    logic                                 wr_en;
    logic [1:0]                           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[mdfs_pkg::ADDR_BITS-1:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_bytes_reg <= (8*mdfs_pkg::MAX_SEP_BYTES)'(44);
            sep_len_reg   <= mdfs_pkg::sep_len_t'(1);
            trim_reg      <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                mdfs_pkg::REG_SEP_BYTES: sep_bytes_reg <= pwdata[8*mdfs_pkg::MAX_SEP_BYTES-1:0];
                mdfs_pkg::REG_SEP_LEN:   sep_len_reg   <= pwdata[mdfs_pkg::SEP_LEN_BITS-1:0];
                mdfs_pkg::REG_TRIM:      trim_reg      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            mdfs_pkg::REG_SEP_BYTES: prdata = mdfs_pkg::DATA_BITS'(sep_bytes_reg);
            mdfs_pkg::REG_SEP_LEN:   prdata = mdfs_pkg::DATA_BITS'(sep_len_reg);
            mdfs_pkg::REG_TRIM:      prdata = mdfs_pkg::DATA_BITS'(trim_reg);
            default:                 prdata = '0;
        endcase
    end

    always_comb begin
        cfg.sep_bytes = sep_bytes_reg;
        cfg.trim      = trim_reg;
        if (sep_len_reg == '0) begin
            cfg.sep_len = mdfs_pkg::sep_len_t'(1);
        end else if (sep_len_reg > mdfs_pkg::sep_len_t'(mdfs_pkg::MAX_SEP_BYTES)) begin
            cfg.sep_len = mdfs_pkg::sep_len_t'(mdfs_pkg::MAX_SEP_BYTES);
        end else begin
            cfg.sep_len = sep_len_reg;
        end
    end

endmodule

FILE: rtl/mdfs_core.sv
// Separator matcher, field tracking and result queue of the field splitter.
`include "multibyte_delimiter_field_splitter_defines.svh"

module mdfs_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  mdfs_pkg::cfg_t   cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             s_end_of_line,
    output logic             m_valid,
    input  logic             m_ready,
    output mdfs_pkg::res_t   m_res
);

    // Pending prefix of p separator bytes ending before end_pos becomes content.
    function automatic mdfs_pkg::pos_t absorb(
        input mdfs_pkg::sep_len_t           p,
        input mdfs_pkg::pos_t               end_pos,
        input mdfs_pkg::pos_t               start,
        input mdfs_pkg::pos_t               cen,
        input logic [mdfs_pkg::MAX_SEP_BYTES-1:0] nonsp
    );
        logic               found;
        mdfs_pkg::sep_len_t back;
        mdfs_pkg::pos_t     ne;
        found = 1'b0;
        back  = '0;
        for (int k = 0; k < mdfs_pkg::MAX_SEP_BYTES; k++) begin
            if ((mdfs_pkg::sep_len_t'(k) < p) && nonsp[k]) begin
                found = 1'b1;
                back  = p - mdfs_pkg::sep_len_t'(k) - mdfs_pkg::sep_len_t'(1);
            end
        end
        ne = (end_pos >= mdfs_pkg::pos_t'(back)) ? end_pos - mdfs_pkg::pos_t'(back) : '0;
        if (ne < start) ne = start;
        absorb = (found && (ne > cen)) ? ne : cen;
    endfunction

    function automatic mdfs_pkg::pos_t span(input mdfs_pkg::pos_t s, input mdfs_pkg::pos_t e);
        span = (e > s) ? e - s : '0;
    endfunction

    mdfs_pkg::pos_t     pos_reg, pos_next;
    mdfs_pkg::pos_t     start_reg, start_next;
    mdfs_pkg::pos_t     cen_reg, cen_next;
    mdfs_pkg::sep_len_t p_reg, p_next;
    mdfs_pkg::field_t   fc_reg, fc_next;
    logic               ovf_reg, ovf_next;

    mdfs_pkg::res_t     fifo_mem [mdfs_pkg::FIFO_DEPTH];
    logic [mdfs_pkg::PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [mdfs_pkg::CNT_BITS-1:0] cnt_reg;

    logic [mdfs_pkg::MAX_SEP_BYTES-1:0] nonsp;
    logic               accept, pop, at_max, ovf1, abandon, hit, matched;
    mdfs_pkg::pos_t     nxt, cen1, cen2, cen3, sstart, end_m, end_e;
    mdfs_pkg::sep_len_t p1, pinc, p2;
    mdfs_pkg::field_t   fc_inc;
    mdfs_pkg::res_t     res0, res1;
    logic               push0, push1;

    always_comb begin
        for (int k = 0; k < mdfs_pkg::MAX_SEP_BYTES; k++) begin
            nonsp[k] = cfg.sep_bytes[8*k +: 8] != mdfs_pkg::SPACE;
        end
    end

    assign accept = s_valid && s_ready;
    assign m_valid = cnt_reg != '0;
    assign pop    = m_valid && m_ready;
    assign s_ready = cnt_reg <= mdfs_pkg::CNT_BITS'(mdfs_pkg::FIFO_DEPTH - 2);
    assign m_res  = fifo_mem[rd_ptr_reg];

    always_comb begin
        at_max  = pos_reg == mdfs_pkg::POS_MAX;
        ovf1    = ovf_reg || at_max;
        nxt     = at_max ? pos_reg : pos_reg + mdfs_pkg::pos_t'(1);

        abandon = (p_reg >= cfg.sep_len) ||
                  ((p_reg != '0) && (s_data_byte != cfg.sep_bytes[8*p_reg[2:0] +: 8]));
        cen1    = abandon ? absorb(p_reg, pos_reg, start_reg, cen_reg, nonsp) : cen_reg;
        p1      = abandon ? '0 : p_reg;
        hit     = s_data_byte == cfg.sep_bytes[8*p1[2:0] +: 8];
        pinc    = p1 + mdfs_pkg::sep_len_t'(1);
        matched = hit && (pinc == cfg.sep_len);
        p2      = (hit && !matched) ? pinc : '0;
        cen2    = (!hit && (s_data_byte != mdfs_pkg::SPACE)) ? nxt : cen1;

        sstart  = (nxt >= mdfs_pkg::pos_t'(cfg.sep_len)) ? nxt - mdfs_pkg::pos_t'(cfg.sep_len) : '0;
        if (sstart < start_reg) sstart = start_reg;
        end_m   = (cfg.trim && (cen1 < sstart)) ? cen1 : sstart;
        fc_inc  = (fc_reg < mdfs_pkg::FIELD_MAX) ? fc_reg + mdfs_pkg::field_t'(1) : fc_reg;

        cen3    = absorb(p2, nxt, start_reg, cen2, nonsp);
        end_e   = (cfg.trim && (cen3 < nxt)) ? cen3 : nxt;

        res0.field_number  = fc_reg;
        res0.last_field    = !matched;
        res0.line_overflow = ovf1;
        if (matched) begin
            res0.field_offset = mdfs_pkg::OUT_POS_BITS'(start_reg);
            res0.field_length = mdfs_pkg::OUT_POS_BITS'(span(start_reg, end_m));
        end else begin
            res0.field_offset = mdfs_pkg::OUT_POS_BITS'(start_reg);
            res0.field_length = mdfs_pkg::OUT_POS_BITS'(span(start_reg, end_e));
        end
        res1.field_number  = fc_inc;
        res1.field_offset  = mdfs_pkg::OUT_POS_BITS'(nxt);
        res1.field_length  = '0;
        res1.last_field    = 1'b1;
        res1.line_overflow = ovf1;

        push0 = accept && (matched || s_end_of_line);
        push1 = accept && matched && s_end_of_line;

        pos_next   = pos_reg;
        start_next = start_reg;
        cen_next   = cen_reg;
        p_next     = p_reg;
        fc_next    = fc_reg;
        ovf_next   = ovf_reg;
        if (accept) begin
            if (s_end_of_line) begin
                pos_next   = '0;
                start_next = '0;
                cen_next   = '0;
                p_next     = '0;
                fc_next    = '0;
                ovf_next   = 1'b0;
            end else begin
                pos_next = nxt;
                ovf_next = ovf1;
                p_next   = p2;
                if (matched) begin
                    start_next = nxt;
                    cen_next   = nxt;
                    fc_next    = fc_inc;
                end else begin
                    cen_next   = cen2;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            start_reg  <= '0;
            cen_reg    <= '0;
            p_reg      <= '0;
            fc_reg     <= '0;
            ovf_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            cen_reg    <= cen_next;
            p_reg      <= p_next;
            fc_reg     <= fc_next;
            ovf_reg    <= ovf_next;
            wr_ptr_reg <= wr_ptr_reg + mdfs_pkg::PTR_BITS'(push0) + mdfs_pkg::PTR_BITS'(push1);
            rd_ptr_reg <= rd_ptr_reg + mdfs_pkg::PTR_BITS'(pop);
            cnt_reg    <= cnt_reg + mdfs_pkg::CNT_BITS'(push0) + mdfs_pkg::CNT_BITS'(push1)
                          - mdfs_pkg::CNT_BITS'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push0) fifo_mem[wr_ptr_reg] <= res0;
        if (push1) fifo_mem[wr_ptr_reg + mdfs_pkg::PTR_BITS'(1)] <= res1;
    end

    `MDFS_ASSERT_NOW(a_queue_bound, aclk, aresetn, 1'b1,
        cnt_reg <= mdfs_pkg::CNT_BITS'(mdfs_pkg::FIFO_DEPTH))
    `MDFS_ASSERT_NEXT(a_line_restart, aclk, aresetn, accept && s_end_of_line,
        pos_reg == '0 && fc_reg == '0 && p_reg == '0)
    `MDFS_ASSERT_NEXT(a_partial_below_len, aclk, aresetn, accept && !s_end_of_line,
        p_reg < $past(cfg.sep_len))
    `MDFS_ASSERT_NOW(a_start_le_pos, aclk, aresetn, 1'b1, start_reg <= pos_reg)

endmodule

FILE: rtl/multibyte_delimiter_field_splitter.sv
// Top level of the multibyte delimiter field splitter.
// One byte of a line is taken per transfer and per cycle while s_ready is high: the
// separator compare and all position and field updates finish in the cycle the
// byte is accepted. A byte yields zero, one or two field records (two when a
// separator completes on the line's last byte); records go into a four-entry
// queue that drains one per cycle while m_ready is high; the input stalls only
// while the queue has fewer than two free entries. Registers sit on APB at byte
// addresses 0 (separator bytes, 64 bits), 8 (separator length) and 16 (trim
// enable), and are to be written only while the splitter is idle.
module multibyte_delimiter_field_splitter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mdfs_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [mdfs_pkg::DATA_BITS-1:0]    pwdata,
    output logic [mdfs_pkg::DATA_BITS-1:0]    prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_data_byte,
    input  logic                              s_end_of_line,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mdfs_pkg::FIELD_BITS-1:0]   m_field_number,
    output logic [mdfs_pkg::OUT_POS_BITS-1:0] m_field_offset,
    output logic [mdfs_pkg::OUT_POS_BITS-1:0] m_field_length,
    output logic                              m_last_field,
    output logic                              m_line_overflow
);

    mdfs_pkg::cfg_t cfg;
    mdfs_pkg::res_t m_res;

    mdfs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mdfs_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_end_of_line (s_end_of_line),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_res         (m_res)
    );

    assign m_field_number  = m_res.field_number;
    assign m_field_offset  = m_res.field_offset;
    assign m_field_length  = m_res.field_length;
    assign m_last_field    = m_res.last_field;
    assign m_line_overflow = m_res.line_overflow;

endmodule
